[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the view history table RTL.
// They are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CVHT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CVHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CVHT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CVHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/cvht_pkg.sv]
// ----------------------------------------------------------------------------
// cvht_pkg
// Types and constants shared by the commit view history table modules.
// ----------------------------------------------------------------------------
package cvht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VER_W       = 63;
  localparam int VIEW_W      = 32;
  localparam int ENTRY_W     = VER_W + VIEW_W;

  localparam logic MODE_COMMIT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMMIT,
    ST_SEARCH,
    ST_COMPARE,
    ST_VIEW,
    ST_DONE
  } cvht_state_e;

  typedef struct packed {
    logic [VIEW_W-1:0] view;
    logic [VER_W-1:0]  first_version;
  } cvht_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    cvht_entry_t      wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } cvht_mem_req_t;

endpackage

[src/cvht_mem.sv]
// ----------------------------------------------------------------------------
// cvht_mem
// History entry storage: one write port, one read port, registered read data.
// Entry 0 is never written and always reads as zero.
// ----------------------------------------------------------------------------
module cvht_mem
  import cvht_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cvht_mem_req_t req_i,
  output cvht_entry_t   rdata_o
);

  cvht_entry_t mem_q [TABLE_DEPTH];
  cvht_entry_t rdata_q;
  logic        rd_zero_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_zero_q <= 1'b1;
    end else if (req_i.re) begin
      rd_zero_q <= (req_i.raddr == '0);
    end
  end

  assign rdata_o = rd_zero_q ? '0 : rdata_q;

endmodule

[src/cvht_ctrl.sv]
// ----------------------------------------------------------------------------
// cvht_ctrl
// Sequencer: applies commits to the last-commit registers and the history
// memory, and runs a binary search over the sorted history for lookups.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cvht_ctrl
  import cvht_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_mode_i,
  input  logic [VER_W-1:0]  in_version_i,
  input  logic [VIEW_W-1:0] in_view_i,
  output logic              res_valid_o,
  input  logic              res_taken_i,
  output logic [VIEW_W-1:0] res_view_o,
  output logic              res_applied_o,
  output logic              res_full_o,
  output cvht_mem_req_t     mem_req_o,
  input  cvht_entry_t       mem_rdata_i
);

  cvht_state_e       state_q, state_d;
  logic [VER_W-1:0]  ver_q, ver_d;
  logic [VIEW_W-1:0] view_q, view_d;
  logic [VER_W-1:0]  last_ver_q, last_ver_d;
  logic [VIEW_W-1:0] last_view_q, last_view_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [VIEW_W-1:0] res_view_q, res_view_d;
  logic              res_applied_q, res_applied_d;
  logic              res_full_q, res_full_d;

  logic              search_more;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;
  logic [CNT_W-1:0]  count_m1;
  logic              stale, new_view, full;

  assign search_more = lo_q < hi_q;
  // Upper middle, so that the interval always shrinks when lo moves up.
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q} + {{IDX_W{1'b0}}, 1'b1};
  assign mid         = mid_sum[IDX_W:1];
  assign count_m1    = count_q - {{(CNT_W-1){1'b0}}, 1'b1};
  assign stale       = (ver_q == '0) || (ver_q <= last_ver_q);
  assign new_view    = last_view_q < view_q;
  assign full        = count_q >= CNT_W'(TABLE_DEPTH);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_mode_i == MODE_LOOKUP) ? ST_SEARCH : ST_COMMIT;
        end
      end
      ST_COMMIT:  state_d = ST_DONE;
      ST_SEARCH:  state_d = search_more ? ST_COMPARE : ST_VIEW;
      ST_COMPARE: state_d = ST_SEARCH;
      ST_VIEW:    state_d = ST_DONE;
      ST_DONE: begin
        if (res_taken_i) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    ver_d         = ver_q;
    view_d        = view_q;
    last_ver_d    = last_ver_q;
    last_view_d   = last_view_q;
    count_d       = count_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    res_view_d    = res_view_q;
    res_applied_d = res_applied_q;
    res_full_d    = res_full_q;
    mem_req_o     = '0;
    in_stall_o    = 1'b1;
    res_valid_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ver_d  = in_version_i;
          view_d = in_view_i;
          lo_d   = '0;
          hi_d   = count_m1[IDX_W-1:0];
        end
      end
      ST_COMMIT: begin
        res_view_d    = '0;
        res_applied_d = 1'b0;
        res_full_d    = 1'b0;
        if (!stale) begin
          if (new_view && full) begin
            res_full_d = 1'b1;
          end else begin
            if (new_view) begin
              mem_req_o.we                  = 1'b1;
              mem_req_o.waddr               = count_q[IDX_W-1:0];
              mem_req_o.wdata.view          = view_q;
              mem_req_o.wdata.first_version = last_ver_q + {{(VER_W-1){1'b0}}, 1'b1};
              count_d                       = count_q + {{(CNT_W-1){1'b0}}, 1'b1};
              last_view_d                   = view_q;
            end
            last_ver_d    = ver_q;
            res_applied_d = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        mem_req_o.re = 1'b1;
        if (search_more) begin
          mem_req_o.raddr = mid;
          mid_d           = mid;
        end else begin
          mem_req_o.raddr = lo_q;
        end
      end
      ST_COMPARE: begin
        if (mem_rdata_i.first_version <= ver_q) begin
          lo_d = mid_q;
        end else begin
          hi_d = mid_q - {{(IDX_W-1){1'b0}}, 1'b1};
        end
      end
      ST_VIEW: begin
        res_view_d    = mem_rdata_i.view;
        res_applied_d = 1'b0;
        res_full_d    = 1'b0;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_ver_q  <= '0;
      last_view_q <= '0;
      count_q     <= CNT_W'(1);
    end else begin
      state_q     <= state_d;
      last_ver_q  <= last_ver_d;
      last_view_q <= last_view_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ver_q         <= ver_d;
    view_q        <= view_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    mid_q         <= mid_d;
    res_view_q    <= res_view_d;
    res_applied_q <= res_applied_d;
    res_full_q    <= res_full_d;
  end

  assign res_view_o    = res_view_q;
  assign res_applied_o = res_applied_q;
  assign res_full_o    = res_full_q;

  `CVHT_ASSERT_SAME(a_count_range, clk_i, rst_ni, 1'b1,
                    (count_q != '0) && (count_q <= CNT_W'(TABLE_DEPTH)))
  `CVHT_ASSERT_NEXT(a_append_grows, clk_i, rst_ni,
                    (state_q == ST_COMMIT) && !stale && new_view && !full,
                    count_q == $past(count_q) + {{(CNT_W-1){1'b0}}, 1'b1})
  `CVHT_ASSERT_SAME(a_search_order, clk_i, rst_ni,
                    (state_q == ST_COMPARE), (lo_q < mid_q) && (mid_q <= hi_q))
  `CVHT_ASSERT_SAME(a_result_flags, clk_i, rst_ni,
                    res_valid_o, !(res_applied_q && res_full_q))

endmodule

[src/commit_view_history_table_core.sv]
// ----------------------------------------------------------------------------
// commit_view_history_table_core
// Commit/lookup front end with a one-beat output register.
// A commit beat passes through a commit state and a done state; a lookup
// beat runs a binary search over the history entries, with one memory read
// and one compare per search step.
// One beat is in work at a time; the next beat is taken once its
// predecessor's result has moved into the output register, which lets it in
// while the last result waits.
// Reset empties the history to its single zero entry.
// ----------------------------------------------------------------------------
module commit_view_history_table_core
  import cvht_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_mode_i,
  input  logic [VER_W-1:0]  in_version_i,
  input  logic [VIEW_W-1:0] in_view_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [VIEW_W-1:0] out_result_view_o,
  output logic              out_commit_applied_o,
  output logic              out_table_full_o
);

  cvht_mem_req_t     mem_req;
  cvht_entry_t       mem_rdata;
  logic              res_valid, res_taken;
  logic [VIEW_W-1:0] res_view;
  logic              res_applied, res_full;

  logic              out_valid_q, out_valid_d;
  logic [VIEW_W-1:0] out_view_q;
  logic              out_applied_q, out_full_q;

  cvht_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_mode_i     (in_mode_i),
    .in_version_i  (in_version_i),
    .in_view_i     (in_view_i),
    .res_valid_o   (res_valid),
    .res_taken_i   (res_taken),
    .res_view_o    (res_view),
    .res_applied_o (res_applied),
    .res_full_o    (res_full),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  cvht_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result when empty or being drained.
  assign res_taken = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (res_taken) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      out_view_q    <= res_view;
      out_applied_q <= res_applied;
      out_full_q    <= res_full;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_result_view_o    = out_view_q;
  assign out_commit_applied_o = out_applied_q;
  assign out_table_full_o     = out_full_q;

endmodule

[tb/commit_view_history_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// commit_view_history_table_checker
// Watches both channels of the commit view history table. Every accepted
// input beat runs through a local model of the view history, and the result
// it gives is queued. Every accepted output beat is compared field by field
// with the oldest queued result.
// ----------------------------------------------------------------------------
module commit_view_history_table_checker
  import cvht_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              in_mode_i,
  input  logic [VER_W-1:0]  in_version_i,
  input  logic [VIEW_W-1:0] in_view_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [VIEW_W-1:0] out_result_view_i,
  input  logic              out_commit_applied_i,
  input  logic              out_table_full_i,
  output int                pending_o,
  output int                fail_count_o
);

  typedef struct packed {
    logic [VIEW_W-1:0] view;
    logic              applied;
    logic              full;
  } view_result_t;

  logic [VER_W-1:0]  last_ver;
  logic [VIEW_W-1:0] last_view;
  logic [VIEW_W-1:0] hist_view [TABLE_DEPTH];
  logic [VER_W-1:0]  hist_first [TABLE_DEPTH];
  int                hist_count;
  view_result_t      result_q [$];
  int                errors = 0;

  // Applies one beat to the local history and returns the result it causes.
  function automatic view_result_t apply_beat(input logic              mode,
                                              input logic [VER_W-1:0]  ver,
                                              input logic [VIEW_W-1:0] view);
    view_result_t res;
    int           idx;
    res = '0;
    if (mode == MODE_LOOKUP) begin
      // Newest entry that starts at or below the queried version.
      for (idx = hist_count - 1; idx >= 0; idx--) begin
        if (hist_first[idx] <= ver) begin
          res.view = hist_view[idx];
          break;
        end
      end
      return res;
    end
    if (ver == '0 || ver <= last_ver) begin
      return res;
    end
    if (view > last_view) begin
      if (hist_count >= TABLE_DEPTH) begin
        res.full = 1'b1;
        return res;
      end
      hist_view[hist_count]  = view;
      hist_first[hist_count] = last_ver + 1'b1;
      hist_count++;
      last_view = view;
    end
    last_ver    = ver;
    res.applied = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    view_result_t want;
    if (!rst_ni) begin
      last_ver   = '0;
      last_view  = '0;
      hist_count = 1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        hist_view[i]  = '0;
        hist_first[i] = '0;
      end
      result_q.delete();
    end else begin
      // Outputs first: a result can never belong to a beat taken at this edge.
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: output beat with no result expected (view %h applied %b full %b)",
                   $time, out_result_view_i, out_commit_applied_i, out_table_full_i);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_result_view_i !== want.view) begin
            $display("%0t: result_view expected %h got %h",
                     $time, want.view, out_result_view_i);
            errors++;
          end
          if (out_commit_applied_i !== want.applied) begin
            $display("%0t: commit_applied expected %b got %b",
                     $time, want.applied, out_commit_applied_i);
            errors++;
          end
          if (out_table_full_i !== want.full) begin
            $display("%0t: table_full expected %b got %b",
                     $time, want.full, out_table_full_i);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        result_q.push_back(apply_beat(in_mode_i, in_version_i, in_view_i));
      end
    end
    pending_o    <= result_q.size();
    fail_count_o <= errors;
  end

endmodule

[tb/commit_view_history_table_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// commit_view_history_table_core_tb
// Drives commit and lookup beats into the view history table: a directed
// opening, about two thousand random beats, nearly half of them rising commit
// sequences, and a closing run that fills the table. Both sides idle and
// stall at random; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module commit_view_history_table_core_tb;
  import cvht_pkg::*;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall_o;
  logic              in_mode      = MODE_COMMIT;
  logic [VER_W-1:0]  in_version   = '0;
  logic [VIEW_W-1:0] in_view      = '0;
  logic              out_valid_o;
  logic              out_stall    = 1'b0;
  logic [VIEW_W-1:0] out_result_view_o;
  logic              out_commit_applied_o;
  logic              out_table_full_o;
  int                pending;
  int                fail_count;

  // Highest version and view of the well-formed commits so far; used to shape stimulus.
  logic [VER_W-1:0]  top_ver  = '0;
  logic [VIEW_W-1:0] top_view = '0;
  bit                rx_hold_req = 1'b0;
  bit                no_gaps     = 1'b0;

  commit_view_history_table_core dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall_o),
    .in_mode_i            (in_mode),
    .in_version_i         (in_version),
    .in_view_i            (in_view),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall),
    .out_result_view_o    (out_result_view_o),
    .out_commit_applied_o (out_commit_applied_o),
    .out_table_full_o     (out_table_full_o)
  );

  commit_view_history_table_checker checker_i (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall_o),
    .in_mode_i            (in_mode),
    .in_version_i         (in_version),
    .in_view_i            (in_view),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall),
    .out_result_view_i    (out_result_view_o),
    .out_commit_applied_i (out_commit_applied_o),
    .out_table_full_i     (out_table_full_o),
    .pending_o            (pending),
    .fail_count_o         (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [VER_W-1:0] rand_version();
    return VER_W'({$urandom, $urandom});
  endfunction

  function automatic logic [VER_W-1:0] rand_upto(input logic [VER_W-1:0] limit);
    if (limit == '1) begin
      return rand_version();
    end
    return rand_version() % (limit + 1'b1);
  endfunction

  // Holds the beat until the block takes it; valid stays high afterwards.
  task automatic send_beat(input logic              mode,
                           input logic [VER_W-1:0]  ver,
                           input logic [VIEW_W-1:0] view);
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_version <= ver;
    in_view    <= view;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) begin
      n = 0;
    end else if (r < 90) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(10, 40);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic beat(input logic              mode,
                      input logic [VER_W-1:0]  ver,
                      input logic [VIEW_W-1:0] view);
    send_beat(mode, ver, view);
    idle_gap();
  endtask

  task automatic random_beat();
    int                r;
    logic [VER_W-1:0]  ver;
    logic [VIEW_W-1:0] view;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        ver = rand_upto(top_ver + 64);
      end else if (r < 8 && top_ver > 2000) begin
        ver = top_ver - $urandom_range(0, 2000);
      end else begin
        ver = rand_version();
      end
      beat(MODE_LOOKUP, ver, $urandom);
    end else if (r < 85) begin
      // Well-formed commit: the version climbs, now and then the view too.
      if ($urandom_range(0, 19) == 0) begin
        ver = top_ver + rand_version() % (63'd1 << 40) + 1'b1;
      end else begin
        ver = top_ver + $urandom_range(1, 1000);
      end
      top_ver = ver;
      if ($urandom_range(0, 99) < 12) begin
        view     = top_view + $urandom_range(1, 1 << 25);
        top_view = view;
      end else begin
        view = $urandom_range(0, top_view);
      end
      beat(MODE_COMMIT, ver, view);
    end else if (r < 95) begin
      beat(MODE_COMMIT, rand_upto(top_ver), $urandom);
    end else begin
      beat(MODE_COMMIT, '0, $urandom);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none while the sender runs without gaps.
  initial begin
    int r;
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (no_gaps) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(15, 60)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lookups on the single zero entry, at both ends of the version range.
    beat(MODE_LOOKUP, '0, '1);
    beat(MODE_LOOKUP, '1, '0);
    // Zero version, then a commit in the same view, then stale commits.
    beat(MODE_COMMIT, '0, 32'd5);
    beat(MODE_COMMIT, 63'd10, '0);
    beat(MODE_COMMIT, 63'd10, 32'd7);
    beat(MODE_COMMIT, 63'd5, 32'd7);
    // A higher view opens an entry starting one above the last version.
    beat(MODE_COMMIT, 63'd20, 32'd3);
    beat(MODE_LOOKUP, 63'd10, '0);
    beat(MODE_LOOKUP, 63'd11, '0);
    beat(MODE_LOOKUP, 63'd20, '0);
    // Lower and same views are accepted without a new entry; then a higher view opens one.
    beat(MODE_COMMIT, 63'd30, 32'd1);
    beat(MODE_COMMIT, 63'd31, 32'd3);
    beat(MODE_COMMIT, 63'd40, 32'd100);
    beat(MODE_LOOKUP, 63'd31, '1);
    beat(MODE_LOOKUP, 63'd32, '0);
    beat(MODE_LOOKUP, 63'd40, '0);
    beat(MODE_LOOKUP, '1, '1);
    top_ver  = 63'd40;
    top_view = 32'd100;

    for (n = 0; n < 2000; n++) begin
      if (n == 500) begin
        rx_hold_req = 1'b1;
      end
      if (n == 1000) begin
        // Let the block drain completely before going on.
        in_valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      no_gaps = (n >= 1200 && n < 1400);
      random_beat();
    end

    // Rising views until the table is certainly full, then the full cases.
    repeat (64) begin
      top_view = top_view + 1'b1;
      top_ver  = top_ver + 1'b1;
      beat(MODE_COMMIT, top_ver, top_view);
    end
    beat(MODE_COMMIT, top_ver + 1'b1, top_view + 1'b1);
    beat(MODE_COMMIT, top_ver + 2'd2, top_view);
    beat(MODE_COMMIT, top_ver + 2'd3, '1);
    beat(MODE_COMMIT, '1, top_view);
    beat(MODE_COMMIT, '1, '1);
    beat(MODE_LOOKUP, '1, '0);
    beat(MODE_LOOKUP, '0, '0);
    beat(MODE_LOOKUP, top_ver, '0);

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
